// ===== hw/rtl/rwlm_pkg.sv =====
// Shared types and constants of the reader-writer lock manager.
// Used by every module of the block, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package rwlm_pkg;

	localparam int REQ_TYPE_W   = 3;
	localparam int TID_W        = 4;
	localparam int KIND_W       = 3;
	localparam int READERS_W    = 8;

	localparam int QUEUE_DEPTH_DEF      = 16;
	localparam int THREAD_ID_BITS_DEF   = 4;
	localparam int READER_COUNT_MAX_DEF = 255;

	// Request type codes as they arrive on the request channel.
	localparam logic [REQ_TYPE_W-1:0] REQ_READ      = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_TRY_READ  = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_WRITE     = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_TRY_WRITE = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNLOCK    = 3'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_GRANTED  = 3'd0,
		KIND_REFUSED  = 3'd1,
		KIND_QUEUED   = 3'd2,
		KIND_RELEASED = 3'd3,
		KIND_IDLE     = 3'd4,
		KIND_WOKEN    = 3'd5,
		KIND_FULL     = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		OP_READ,
		OP_TRY_READ,
		OP_WRITE,
		OP_TRY_WRITE,
		OP_UNLOCK,
		OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAKE
	} state_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [TID_W-1:0]      thread_id;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0]    result_kind;
		logic [TID_W-1:0]     result_thread;
		logic                 last;
		logic [READERS_W-1:0] readers_now;
		logic                 writer_now;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic [TID_W-1:0] tid;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rwlm_stream_if.sv =====
// Valid/ready stream interface with a payload of a given type.
// Depends on nothing; the payload types come from rwlm_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface rwlm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rwlm_front.sv =====
// Front end: accepts lock requests, decodes them into operations and holds
// them in a two-entry command queue. Depends on rwlm_pkg and rwlm_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module rwlm_front #(
	parameter int THREAD_ID_BITS = rwlm_pkg::THREAD_ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	rwlm_stream_if.sink        request,
	output logic               cmd_valid,
	output rwlm_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);
	localparam int TB = (THREAD_ID_BITS < rwlm_pkg::TID_W) ? THREAD_ID_BITS
		: rwlm_pkg::TID_W;
	localparam logic [rwlm_pkg::TID_W-1:0] TID_MASK =
		rwlm_pkg::TID_W'((1 << TB) - 1);

	rwlm_pkg::cmd_t cmd_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	rwlm_pkg::cmd_t decoded;

	always_comb begin
		decoded.tid = request.data.thread_id & TID_MASK;
		case (request.data.req_type)
			rwlm_pkg::REQ_READ:      decoded.op = rwlm_pkg::OP_READ;
			rwlm_pkg::REQ_TRY_READ:  decoded.op = rwlm_pkg::OP_TRY_READ;
			rwlm_pkg::REQ_WRITE:     decoded.op = rwlm_pkg::OP_WRITE;
			rwlm_pkg::REQ_TRY_WRITE: decoded.op = rwlm_pkg::OP_TRY_WRITE;
			rwlm_pkg::REQ_UNLOCK:    decoded.op = rwlm_pkg::OP_UNLOCK;
			default:                 decoded.op = rwlm_pkg::OP_BAD;
		endcase
	end

	assign request.ready = (cnt_q != 2'd2);
	assign push          = request.valid && request.ready;
	assign cmd_valid     = (cnt_q != 2'd0);
	assign cmd           = cmd_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rwlm_wait_fifo.sv =====
// Wait queue of thread numbers: a circular buffer in a memory with a write port and
// a registered read port. Depends on rwlm_pkg for its control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rwlm_wait_fifo #(
	parameter int DEPTH = rwlm_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = rwlm_pkg::TID_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rwlm_pkg::fifo_ctl_t        ctl,
	input  logic [WIDTH-1:0]           wdata,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output rwlm_pkg::fifo_stat_t       stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign rdata      = rdata_q;
	assign count      = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_q] <= wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (ctl.pop) begin
				head_q <= wrap_inc(head_q);
			end
			count_q <= count_q + CW'(ctl.push) - CW'(ctl.pop);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rwlm_back.sv =====
// Back end: lock state, the two wait queues and the sequencer that carries
// out one command and emits its results through an output register.
// Depends on rwlm_pkg, rwlm_stream_if and rwlm_wait_fifo.
`timescale 1ns / 1ps
`default_nettype none

module rwlm_back #(
	parameter int QUEUE_DEPTH      = rwlm_pkg::QUEUE_DEPTH_DEF,
	parameter int THREAD_ID_BITS   = rwlm_pkg::THREAD_ID_BITS_DEF,
	parameter int READER_COUNT_MAX = rwlm_pkg::READER_COUNT_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  rwlm_pkg::cmd_t cmd,
	output logic           cmd_pop,
	rwlm_stream_if.source  result
);
	localparam int TB  = (THREAD_ID_BITS < rwlm_pkg::TID_W) ? THREAD_ID_BITS
		: rwlm_pkg::TID_W;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int RCW = $clog2(READER_COUNT_MAX + 1);

	rwlm_pkg::state_t     state_q, state_d;
	rwlm_pkg::cmd_t       cmd_q;
	logic [RCW-1:0]       rc_q, rc_d;
	logic                 wh_q, wh_d;
	logic [CW-1:0]        wake_left_q, wake_left_d;
	logic                 wake_rd_q, wake_rd_d;
	logic                 out_valid_q;
	rwlm_pkg::rsp_t       out_q, emit_data;
	logic                 emit;
	logic                 can_emit;
	logic                 start_wake;

	rwlm_pkg::fifo_ctl_t  wq_ctl, rq_ctl;
	rwlm_pkg::fifo_stat_t wq_stat, rq_stat;
	logic [TB-1:0]        wq_rdata, rq_rdata;
	logic [CW-1:0]        wq_count, rq_count;
	logic [15:0]          readers_wide;

	rwlm_wait_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(TB)) u_writer_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wq_ctl),
		.wdata  (cmd_q.tid[TB-1:0]),
		.rdata  (wq_rdata),
		.count  (wq_count),
		.stat   (wq_stat)
	);

	rwlm_wait_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(TB)) u_reader_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rq_ctl),
		.wdata  (cmd_q.tid[TB-1:0]),
		.rdata  (rq_rdata),
		.count  (rq_count),
		.stat   (rq_stat)
	);

	assign can_emit     = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign readers_wide = 16'(rc_d);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rwlm_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = rwlm_pkg::ST_EXEC;
				end
			end
			rwlm_pkg::ST_EXEC: begin
				if (can_emit) begin
					state_d = start_wake ? rwlm_pkg::ST_WAKE : rwlm_pkg::ST_IDLE;
				end
			end
			rwlm_pkg::ST_WAKE: begin
				if (can_emit && wake_left_q == CW'(1)) begin
					state_d = rwlm_pkg::ST_IDLE;
				end
			end
			default: state_d = rwlm_pkg::ST_IDLE;
		endcase
	end

	// Lock decision: start_wake depends only on the command, lock state and queue status, not on can_emit.
	always_comb begin
		rc_d        = rc_q;
		wh_d        = wh_q;
		wake_left_d = wake_left_q;
		wake_rd_d   = wake_rd_q;
		wq_ctl      = '0;
		rq_ctl      = '0;
		cmd_pop     = 1'b0;
		emit        = 1'b0;
		start_wake  = 1'b0;
		emit_data   = '0;
		case (state_q)
			rwlm_pkg::ST_IDLE: begin
				cmd_pop = cmd_valid;
			end
			rwlm_pkg::ST_EXEC: begin
				emit_data.result_thread = cmd_q.tid;
				emit_data.result_kind   = rwlm_pkg::KIND_REFUSED;
				case (cmd_q.op)
					rwlm_pkg::OP_READ, rwlm_pkg::OP_TRY_READ: begin
						if (wh_q) begin
							if (cmd_q.op == rwlm_pkg::OP_TRY_READ) begin
								emit_data.result_kind = rwlm_pkg::KIND_REFUSED;
							end else if (rq_stat.full) begin
								emit_data.result_kind = rwlm_pkg::KIND_FULL;
							end else begin
								rq_ctl.push           = can_emit;
								emit_data.result_kind = rwlm_pkg::KIND_QUEUED;
							end
						end else if (rc_q == RCW'(READER_COUNT_MAX)) begin
							emit_data.result_kind = rwlm_pkg::KIND_FULL;
						end else begin
							rc_d                  = rc_q + RCW'(1);
							emit_data.result_kind = rwlm_pkg::KIND_GRANTED;
						end
					end
					rwlm_pkg::OP_WRITE, rwlm_pkg::OP_TRY_WRITE: begin
						if (wh_q || rc_q != '0) begin
							if (cmd_q.op == rwlm_pkg::OP_TRY_WRITE) begin
								emit_data.result_kind = rwlm_pkg::KIND_REFUSED;
							end else if (wq_stat.full) begin
								emit_data.result_kind = rwlm_pkg::KIND_FULL;
							end else begin
								wq_ctl.push           = can_emit;
								emit_data.result_kind = rwlm_pkg::KIND_QUEUED;
							end
						end else begin
							wh_d                  = 1'b1;
							emit_data.result_kind = rwlm_pkg::KIND_GRANTED;
						end
					end
					rwlm_pkg::OP_UNLOCK: begin
						if (wh_q) begin
							wh_d                  = 1'b0;
							emit_data.result_kind = rwlm_pkg::KIND_RELEASED;
							if (!wq_stat.empty) begin
								start_wake  = 1'b1;
								wq_ctl.pop  = can_emit;
								wake_rd_d   = 1'b0;
								wake_left_d = CW'(1);
							end else if (!rq_stat.empty) begin
								// Write unlock with no writer waiting wakes every reader.
								start_wake  = 1'b1;
								rq_ctl.pop  = can_emit;
								wake_rd_d   = 1'b1;
								wake_left_d = rq_count;
							end
						end else if (rc_q != '0) begin
							rc_d                  = rc_q - RCW'(1);
							emit_data.result_kind = rwlm_pkg::KIND_RELEASED;
							if (rc_q == RCW'(1) && !wq_stat.empty) begin
								start_wake  = 1'b1;
								wq_ctl.pop  = can_emit;
								wake_rd_d   = 1'b0;
								wake_left_d = CW'(1);
							end
						end else begin
							emit_data.result_kind = rwlm_pkg::KIND_IDLE;
						end
					end
					default: emit_data.result_kind = rwlm_pkg::KIND_REFUSED;
				endcase
				emit                  = can_emit;
				emit_data.last        = !start_wake;
				emit_data.readers_now = readers_wide[rwlm_pkg::READERS_W-1:0];
				emit_data.writer_now  = wh_d;
			end
			rwlm_pkg::ST_WAKE: begin
				emit                    = can_emit;
				emit_data.result_kind   = rwlm_pkg::KIND_WOKEN;
				emit_data.result_thread = wake_rd_q ? rwlm_pkg::TID_W'(rq_rdata)
					: rwlm_pkg::TID_W'(wq_rdata);
				emit_data.last          = (wake_left_q == CW'(1));
				emit_data.readers_now   = readers_wide[rwlm_pkg::READERS_W-1:0];
				emit_data.writer_now    = wh_q;
				if (can_emit) begin
					wake_left_d = wake_left_q - CW'(1);
					// The next waiting reader is read while this one is sent.
					rq_ctl.pop  = wake_rd_q && (wake_left_q != CW'(1));
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (emit) begin
			out_q <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rwlm_pkg::ST_IDLE;
			rc_q        <= '0;
			wh_q        <= 1'b0;
			wake_left_q <= '0;
			wake_rd_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rc_q        <= rc_d;
				wh_q        <= wh_d;
				wake_left_q <= wake_left_d;
				wake_rd_q   <= wake_rd_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/reader_writer_lock_manager_top.sv =====
// Reader-writer lock manager, top level: front end with command queue and back end
// with lock state and wait queues. Depends on rwlm_pkg, rwlm_stream_if and submodules.
// The back-end sequencer loads a command in its idle state and carries it out in the
// execute state, then sends one wake result per woken thread. It takes no new command
// until the last result of the current one is registered, and waits while the result is stalled.
// Reset (arst_n low) clears lock state, queue counts and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module reader_writer_lock_manager_top #(
	parameter int QUEUE_DEPTH      = rwlm_pkg::QUEUE_DEPTH_DEF,
	parameter int THREAD_ID_BITS   = rwlm_pkg::THREAD_ID_BITS_DEF,
	parameter int READER_COUNT_MAX = rwlm_pkg::READER_COUNT_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rwlm_stream_if.sink   request,
	rwlm_stream_if.source result
);
	logic           cmd_valid;
	logic           cmd_pop;
	rwlm_pkg::cmd_t cmd;

	rwlm_front #(.THREAD_ID_BITS(THREAD_ID_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rwlm_back #(
		.QUEUE_DEPTH      (QUEUE_DEPTH),
		.THREAD_ID_BITS   (THREAD_ID_BITS),
		.READER_COUNT_MAX (READER_COUNT_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rwlm_checker.sv =====
// Port-level checks on the result stream of the lock manager, bound to the
// top level. Depends on rwlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwlm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input rwlm_pkg::rsp_t rsp
);
	// A held write lock excludes every reader.
	a_writer_excludes_readers: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.writer_now |-> rsp.readers_now == '0)
		else $error("write lock reported together with readers");

	// Threads are only woken once the write lock is free.
	a_woken_lock_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == rwlm_pkg::KIND_WOKEN |-> !rsp.writer_now)
		else $error("thread woken while the write lock is held");

	// Only a release can be followed by wake results of the same request.
	a_single_result_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.result_kind == rwlm_pkg::KIND_GRANTED
			|| rsp.result_kind == rwlm_pkg::KIND_REFUSED
			|| rsp.result_kind == rwlm_pkg::KIND_QUEUED
			|| rsp.result_kind == rwlm_pkg::KIND_IDLE
			|| rsp.result_kind == rwlm_pkg::KIND_FULL) |-> rsp.last)
		else $error("non-release result not marked last");

	// A non-final result is always followed by a wake result.
	a_wake_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=> !rsp_valid
			|| rsp.result_kind == rwlm_pkg::KIND_WOKEN)
		else $error("result after a non-final one is not a wake");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

endmodule

bind reader_writer_lock_manager_top rwlm_checker u_rwlm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (result.valid),
	.rsp_ready (result.ready),
	.rsp       (result.data)
);

`default_nettype wire

// ===== tb/sv/reader_writer_lock_manager_top_tb.sv =====
// Self-checking testbench of the reader-writer lock manager top level.
// Drives lock requests, predicts every result item and compares them in order.
// Depends on rwlm_pkg, rwlm_stream_if and reader_writer_lock_manager_top.
`timescale 1ns / 1ps

module reader_writer_lock_manager_top_tb;

	localparam int WAIT_DEPTH     = rwlm_pkg::QUEUE_DEPTH_DEF;
	localparam int READER_LIMIT   = rwlm_pkg::READER_COUNT_MAX_DEF;
	localparam int RANDOM_ITEMS   = 24;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 20;

	// Request codes the block does not define; each must be refused.
	localparam logic [rwlm_pkg::REQ_TYPE_W-1:0] REQ_RESERVED_LO  = 3'd5;
	localparam logic [rwlm_pkg::REQ_TYPE_W-1:0] REQ_RESERVED_MID = 3'd6;
	localparam logic [rwlm_pkg::REQ_TYPE_W-1:0] REQ_RESERVED_HI  = 3'd7;

	typedef struct {
		rwlm_pkg::req_t body;
		bit             after_drain;
	} lock_item_t;

	logic clk;
	logic arst_n;

	rwlm_stream_if #(.T(rwlm_pkg::req_t)) req_ch ();
	rwlm_stream_if #(.T(rwlm_pkg::rsp_t)) rsp_ch ();

	reader_writer_lock_manager_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	lock_item_t     lock_requests[$];
	rwlm_pkg::rsp_t lock_results[$];
	int             stim_count = 0;
	int             fail_count = 0;
	int             cycle_count = 0;
	int             send_wait;
	int             send_calm = 0;
	int             recv_wait;
	int             recv_calm = 0;

	// Shadow of the lock state, advanced once per accepted request item.
	int                         rd_count = 0;
	bit                         wr_held = 1'b0;
	logic [rwlm_pkg::TID_W-1:0] wr_waiters[$];
	logic [rwlm_pkg::TID_W-1:0] rd_waiters[$];

	function automatic int draw_idle(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	function automatic logic [rwlm_pkg::TID_W-1:0] rand_tid();
		return rwlm_pkg::TID_W'($urandom_range(0, 15));
	endfunction

	function automatic void predict_request(rwlm_pkg::req_t rq);
		rwlm_pkg::kind_t            first_kind;
		logic [rwlm_pkg::TID_W-1:0] woken[$];
		rwlm_pkg::rsp_t             r;
		first_kind = rwlm_pkg::KIND_REFUSED;
		case (rq.req_type)
			rwlm_pkg::REQ_READ, rwlm_pkg::REQ_TRY_READ: begin
				if (wr_held) begin
					if (rq.req_type == rwlm_pkg::REQ_TRY_READ) begin
						first_kind = rwlm_pkg::KIND_REFUSED;
					end else if (rd_waiters.size() >= WAIT_DEPTH) begin
						first_kind = rwlm_pkg::KIND_FULL;
					end else begin
						rd_waiters.push_back(rq.thread_id);
						first_kind = rwlm_pkg::KIND_QUEUED;
					end
				end else if (rd_count >= READER_LIMIT) begin
					first_kind = rwlm_pkg::KIND_FULL;
				end else begin
					rd_count++;
					first_kind = rwlm_pkg::KIND_GRANTED;
				end
			end
			rwlm_pkg::REQ_WRITE, rwlm_pkg::REQ_TRY_WRITE: begin
				if (wr_held || rd_count != 0) begin
					if (rq.req_type == rwlm_pkg::REQ_TRY_WRITE) begin
						first_kind = rwlm_pkg::KIND_REFUSED;
					end else if (wr_waiters.size() >= WAIT_DEPTH) begin
						first_kind = rwlm_pkg::KIND_FULL;
					end else begin
						wr_waiters.push_back(rq.thread_id);
						first_kind = rwlm_pkg::KIND_QUEUED;
					end
				end else begin
					wr_held = 1'b1;
					first_kind = rwlm_pkg::KIND_GRANTED;
				end
			end
			rwlm_pkg::REQ_UNLOCK: begin
				if (wr_held) begin
					wr_held = 1'b0;
					first_kind = rwlm_pkg::KIND_RELEASED;
					// A waiting writer takes precedence over all waiting readers.
					if (wr_waiters.size() != 0) begin
						woken.push_back(wr_waiters.pop_front());
					end else begin
						woken = rd_waiters;
						rd_waiters.delete();
					end
				end else if (rd_count != 0) begin
					rd_count--;
					first_kind = rwlm_pkg::KIND_RELEASED;
					if (rd_count == 0 && wr_waiters.size() != 0)
						woken.push_back(wr_waiters.pop_front());
				end else begin
					first_kind = rwlm_pkg::KIND_IDLE;
				end
			end
			default: first_kind = rwlm_pkg::KIND_REFUSED;
		endcase

		r.readers_now   = rwlm_pkg::READERS_W'(rd_count);
		r.writer_now    = wr_held;
		r.result_kind   = first_kind;
		r.result_thread = rq.thread_id;
		r.last          = (woken.size() == 0);
		lock_results.push_back(r);
		for (int i = 0; i < woken.size(); i++) begin
			r.result_kind   = rwlm_pkg::KIND_WOKEN;
			r.result_thread = woken[i];
			r.last          = (i == woken.size() - 1);
			lock_results.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic push_req(logic [rwlm_pkg::REQ_TYPE_W-1:0] kind,
			logic [rwlm_pkg::TID_W-1:0] tid, bit drain = 1'b0);
		lock_item_t it;
		it.body.req_type  = kind;
		it.body.thread_id = tid;
		it.after_drain    = drain;
		lock_requests.push_back(it);
		stim_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : request_driver
		bit accepted;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			send_wait = 0;
		end else begin
			accepted = req_ch.valid && req_ch.ready;
			if (accepted) begin
				predict_request(req_ch.data);
				void'(lock_requests.pop_front());
				send_wait = draw_idle(send_calm);
			end
			if (req_ch.valid && !accepted) begin
				// The offered item stays on the channel until it is taken.
			end else if (send_wait > 0) begin
				send_wait--;
				req_ch.valid <= 1'b0;
			end else if (lock_requests.size() != 0 &&
					(!lock_requests[0].after_drain || lock_results.size() == 0)) begin
				req_ch.valid <= 1'b1;
				req_ch.data  <= lock_requests[0].body;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		rwlm_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (lock_results.size() == 0) begin
					$error("result item with nothing expected: kind %0d thread %0d",
						rsp_ch.data.result_kind, rsp_ch.data.result_thread);
					fail_count++;
				end else begin
					want = lock_results.pop_front();
					check_field("result_kind", want.result_kind, rsp_ch.data.result_kind);
					check_field("result_thread", want.result_thread,
						rsp_ch.data.result_thread);
					check_field("last", want.last, rsp_ch.data.last);
					check_field("readers_now", want.readers_now, rsp_ch.data.readers_now);
					check_field("writer_now", want.writer_now, rsp_ch.data.writer_now);
				end
				recv_wait = draw_idle(recv_calm);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : run_watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("reader_writer_lock_manager_top_tb: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		int base;
		logic [rwlm_pkg::REQ_TYPE_W-1:0] op;
		arst_n = 1'b0;

		// Directed part: every request type, reserved codes, all three wake-up paths.
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd0);
		push_req(REQ_RESERVED_LO, 4'd15);
		push_req(REQ_RESERVED_HI, 4'd1);
		push_req(rwlm_pkg::REQ_TRY_READ, 4'd1);
		push_req(rwlm_pkg::REQ_READ, 4'd2);
		push_req(rwlm_pkg::REQ_TRY_WRITE, 4'd3);
		push_req(rwlm_pkg::REQ_WRITE, 4'd4);
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd1);
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd2);
		push_req(rwlm_pkg::REQ_WRITE, 4'd4);
		push_req(rwlm_pkg::REQ_TRY_READ, 4'd5);
		push_req(rwlm_pkg::REQ_READ, 4'd6);
		push_req(rwlm_pkg::REQ_READ, 4'd7);
		push_req(rwlm_pkg::REQ_READ, 4'd15);
		push_req(rwlm_pkg::REQ_TRY_WRITE, 4'd8);
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd4);
		push_req(rwlm_pkg::REQ_READ, 4'd6);
		push_req(rwlm_pkg::REQ_READ, 4'd7);
		push_req(rwlm_pkg::REQ_WRITE, 4'd9);
		push_req(rwlm_pkg::REQ_WRITE, 4'd0);
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd6);
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd7);
		push_req(rwlm_pkg::REQ_WRITE, 4'd9);
		push_req(REQ_RESERVED_MID, 4'd10);
		push_req(rwlm_pkg::REQ_UNLOCK, 4'd9);

		// Both wait queues filled past their depth, then drained; the last unlock
		// wakes every waiting reader at once.
		push_req(rwlm_pkg::REQ_WRITE, rand_tid(), 1'b1);
		for (int i = 0; i <= WAIT_DEPTH; i++)
			push_req(rwlm_pkg::REQ_WRITE, rand_tid());
		for (int i = 0; i <= WAIT_DEPTH; i++)
			push_req(rwlm_pkg::REQ_READ, rand_tid());
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
			push_req(rwlm_pkg::REQ_WRITE, rand_tid());
		end
		push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());

		// Random part: short lock episodes with random content, plus noise.
		base = stim_count;
		while (stim_count < base + RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: begin
					k = $urandom_range(1, 6);
					for (int i = 0; i < k; i++)
						push_req(rwlm_pkg::REQ_TYPE_W'($urandom_range(0, 7)), rand_tid());
				end
				1: begin
					push_req(rwlm_pkg::REQ_WRITE, rand_tid(), $urandom_range(0, 40) == 0);
					k = $urandom_range(0, WAIT_DEPTH + 1);
					for (int i = 0; i < k; i++)
						push_req($urandom_range(0, 3) == 0 ? rwlm_pkg::REQ_TRY_READ
							: rwlm_pkg::REQ_READ, rand_tid());
					push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
					k = $urandom_range(0, k);
					for (int i = 0; i < k; i++)
						push_req(rwlm_pkg::REQ_READ, rand_tid());
				end
				2: begin
					push_req(rwlm_pkg::REQ_WRITE, rand_tid());
					k = $urandom_range(0, WAIT_DEPTH + 1);
					for (int i = 0; i < k; i++)
						push_req($urandom_range(0, 3) == 0 ? rwlm_pkg::REQ_TRY_WRITE
							: rwlm_pkg::REQ_WRITE, rand_tid());
					for (int i = 0; i < k; i++) begin
						push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
						push_req(rwlm_pkg::REQ_WRITE, rand_tid());
					end
					push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
				end
				3: begin
					k = $urandom_range(1, 6);
					for (int i = 0; i < k; i++)
						push_req(rwlm_pkg::REQ_READ, rand_tid());
					push_req(rwlm_pkg::REQ_WRITE, rand_tid());
					push_req(rwlm_pkg::REQ_TRY_WRITE, rand_tid());
					for (int i = 0; i < k; i++)
						push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
					push_req(rwlm_pkg::REQ_WRITE, rand_tid());
					push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
				end
				4: begin
					k = $urandom_range(1, 5);
					for (int i = 0; i < k; i++)
						push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
				end
				default: begin
					op = rwlm_pkg::REQ_TYPE_W'($urandom_range(0, 4));
					push_req(op, rand_tid());
				end
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (lock_requests.size() != 0 || lock_results.size() != 0)
			@(posedge clk);

		// Reader count driven to its ceiling from a free lock. With everything
		// drained, the shadow state tells how many unlocks free the lock first.
		if (wr_held)
			push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
		for (int i = 0; i < rd_count; i++)
			push_req(rwlm_pkg::REQ_UNLOCK, rand_tid());
		for (int i = 0; i < READER_LIMIT; i++)
			push_req(rwlm_pkg::REQ_READ, rand_tid());
		push_req(rwlm_pkg::REQ_READ, rand_tid());
		push_req(rwlm_pkg::REQ_TRY_READ, rand_tid());
		push_req(rwlm_pkg::REQ_WRITE, rand_tid());
		push_req(rwlm_pkg::REQ_TRY_WRITE, rand_tid());

		while (lock_requests.size() != 0 || lock_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("reader_writer_lock_manager_top_tb: PASS");
		end else begin
			$display("reader_writer_lock_manager_top_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== reader_writer_lock_manager_top.f =====
hw/rtl/rwlm_pkg.sv
hw/rtl/rwlm_stream_if.sv
hw/rtl/rwlm_front.sv
hw/rtl/rwlm_wait_fifo.sv
hw/rtl/rwlm_back.sv
hw/rtl/reader_writer_lock_manager_top.sv
hw/rtl/rwlm_checker.sv
tb/sv/reader_writer_lock_manager_top_tb.sv
